// File: rtl/apcs_pkg.sv
// ----------------------------------------------------------------------------
// apcs_pkg
// Types and constants shared by the ATA PIO command sequencer modules.
// ----------------------------------------------------------------------------
package apcs_pkg;

  localparam int unsigned MaxChunk       = 255;
  localparam int unsigned WordsPerSector = 256;
  localparam int unsigned MaxResults     = 6;
  localparam int unsigned QueueDepth     = 2;

  localparam logic [28:0] LbaLimit   = 29'h1000_0000;
  localparam logic [7:0]  DevBase    = 8'he0;
  localparam logic [7:0]  StAllOnes  = 8'hff;
  localparam logic [7:0]  CmdRead    = 8'h20;
  localparam logic [7:0]  CmdWrite   = 8'h30;
  localparam logic [7:0]  CmdFlush   = 8'he7;
  localparam logic [22:0] SpinReset  = 23'd5000000;

  // input op codes
  typedef enum logic [1:0] {
    OP_REQ   = 2'd0,
    OP_RESP  = 2'd1,
    OP_HOSTW = 2'd2,
    OP_NONE  = 2'd3
  } op_e;

  // request kinds
  typedef enum logic [1:0] {
    CMD_READ  = 2'd0,
    CMD_WRITE = 2'd1,
    CMD_FLUSH = 2'd2,
    CMD_UNSUP = 2'd3
  } cmd_e;

  // result kinds
  typedef enum logic [2:0] {
    K_WB    = 3'd0,
    K_RB    = 3'd1,
    K_WW    = 3'd2,
    K_RW    = 3'd3,
    K_NEED  = 3'd4,
    K_DELIV = 3'd5,
    K_DONE  = 3'd6,
    K_RSVD  = 3'd7
  } kind_e;

  // done status codes
  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_IOERR = 2'd2,
    ST_UNSUP = 2'd3
  } status_e;

  // configuration register indexes
  typedef enum logic [1:0] {
    REG_IO_BASE = 2'd0,
    REG_CONTROL = 2'd1,
    REG_DRIVE   = 2'd2,
    REG_SPIN    = 2'd3
  } reg_e;

  typedef struct packed {
    logic [1:0]  op;
    logic [1:0]  cmd;
    logic [47:0] start_block;
    logic [31:0] block_count;
    logic [15:0] data_in;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  kind;
    logic [15:0] port;
    logic [15:0] value;
    logic [1:0]  status_code;
    logic        last;
  } out_item_t;

  // all results caused by one input item
  typedef struct packed {
    out_item_t [MaxResults-1:0] res;
    logic [2:0]                 cnt;
  } bundle_t;

  function automatic out_item_t mk_res(kind_e k, logic [15:0] p, logic [15:0] v,
                                       status_e s);
    out_item_t r;
    r.kind        = k;
    r.port        = p;
    r.value       = v;
    r.status_code = s;
    r.last        = 1'b0;
    return r;
  endfunction

endpackage

// File: rtl/apcs_front.sv
// ----------------------------------------------------------------------------
// apcs_front
// Takes input items, advances the sequencer state and builds the list of
// results that each item causes.
// ----------------------------------------------------------------------------
module apcs_front import apcs_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        accept_i,
  input  in_item_t    item_i,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [22:0] cfg_data_i,
  output logic        push_o,
  output bundle_t     bundle_o
);

  typedef enum logic [3:0] {
    PH_IDLE, PH_W1, PH_DLY, PH_W2, PH_DRQ, PH_RD, PH_WR, PH_WBSY, PH_FBSY, PH_FSTAT
  } phase_e;

  phase_e      phase_q, phase_d;
  logic [1:0]  rk_q, rk_d;
  logic [27:0] lba_q, lba_d;
  logic [28:0] rem_q, rem_d;
  logic [7:0]  chk_q, chk_d;
  logic [7:0]  sec_q, sec_d;
  logic [8:0]  wi_q, wi_d;
  logic [22:0] pc_q, pc_d;

  logic [15:0] io_base_q, ctrl_q;
  logic        drive_q;
  logic [22:0] spin_q;

  out_item_t [MaxResults-1:0] res;
  logic [2:0]  n;
  logic [7:0]  s;
  logic [22:0] lim, pc1;
  logic [28:0] room;
  logic        end_sec, end_chk;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      io_base_q <= 16'd496;
      ctrl_q    <= 16'd1014;
      drive_q   <= 1'b0;
      spin_q    <= SpinReset;
    end else if (cfg_we_i) begin
      unique case (reg_e'(cfg_idx_i))
        REG_IO_BASE: io_base_q <= cfg_data_i[15:0];
        REG_CONTROL: ctrl_q    <= cfg_data_i[15:0];
        REG_DRIVE:   drive_q   <= cfg_data_i[0];
        REG_SPIN:    spin_q    <= cfg_data_i;
        default:     ;
      endcase
    end
  end

  assign s    = item_i.data_in[7:0];
  assign lim  = (spin_q == '0) ? 23'd1 : spin_q;
  assign pc1  = pc_q + 23'd1;
  assign room = LbaLimit - {1'b0, item_i.start_block[27:0]};

  // sequencer step
  always_comb begin
    phase_d = phase_q;
    rk_d    = rk_q;
    lba_d   = lba_q;
    rem_d   = rem_q;
    chk_d   = chk_q;
    sec_d   = sec_q;
    wi_d    = wi_q;
    pc_d    = pc_q;
    res     = '0;
    n       = '0;
    end_sec = 1'b0;
    end_chk = 1'b0;
    if (accept_i) begin
      if (op_e'(item_i.op) == OP_REQ && phase_q == PH_IDLE) begin
        if (cmd_e'(item_i.cmd) == CMD_UNSUP) begin
          res[n] = mk_res(K_DONE, '0, '0, ST_UNSUP); n = n + 3'd1;
        end else begin
          rk_d = item_i.cmd;
          if (cmd_e'(item_i.cmd) == CMD_FLUSH) begin
            lba_d = '0; pc_d = '0; phase_d = PH_W1;
            res[n] = mk_res(K_RB, ctrl_q, '0, ST_OK); n = n + 3'd1;
          end else if (item_i.start_block[47:28] != '0 ||
                       item_i.block_count > {3'b0, room}) begin
            res[n] = mk_res(K_DONE, '0, '0, ST_RANGE); n = n + 3'd1;
          end else if (item_i.block_count == '0) begin
            res[n] = mk_res(K_DONE, '0, '0, ST_OK); n = n + 3'd1;
          end else begin
            lba_d = item_i.start_block[27:0];
            rem_d = item_i.block_count[28:0];
            chk_d = (rem_d > 29'(MaxChunk)) ? 8'(MaxChunk) : rem_d[7:0];
            sec_d = '0; pc_d = '0; phase_d = PH_W1;
            res[n] = mk_res(K_RB, ctrl_q, '0, ST_OK); n = n + 3'd1;
          end
        end
      end else if (op_e'(item_i.op) == OP_RESP && phase_q != PH_IDLE &&
                   phase_q != PH_WR) begin
        unique case (phase_q)
          PH_W1, PH_W2, PH_WBSY, PH_FBSY: begin
            if (s == StAllOnes) begin
              phase_d = PH_IDLE;
              res[n] = mk_res(K_DONE, '0, '0, ST_IOERR); n = n + 3'd1;
            end else if (s[7]) begin
              pc_d = pc1;
              if (pc1 >= lim) begin
                phase_d = PH_IDLE;
                res[n] = mk_res(K_DONE, '0, '0, ST_IOERR); n = n + 3'd1;
              end else begin
                res[n] = mk_res(K_RB, ctrl_q, '0, ST_OK); n = n + 3'd1;
              end
            end else if (phase_q == PH_W1) begin
              res[n] = mk_res(K_WB, io_base_q + 16'd6,
                              {8'd0, DevBase | {3'd0, drive_q, lba_q[27:24]}}, ST_OK);
              n = n + 3'd1;
              pc_d = 23'd1; phase_d = PH_DLY;
              res[n] = mk_res(K_RB, ctrl_q, '0, ST_OK); n = n + 3'd1;
            end else if (phase_q == PH_W2) begin
              if (cmd_e'(rk_q) == CMD_FLUSH) begin
                res[n] = mk_res(K_WB, io_base_q + 16'd7, {8'd0, CmdFlush}, ST_OK);
                n = n + 3'd1;
                pc_d = '0; phase_d = PH_FBSY;
              end else begin
                res[n] = mk_res(K_WB, io_base_q + 16'd2, {8'd0, chk_q}, ST_OK);
                n = n + 3'd1;
                res[n] = mk_res(K_WB, io_base_q + 16'd3, {8'd0, lba_q[7:0]}, ST_OK);
                n = n + 3'd1;
                res[n] = mk_res(K_WB, io_base_q + 16'd4, {8'd0, lba_q[15:8]}, ST_OK);
                n = n + 3'd1;
                res[n] = mk_res(K_WB, io_base_q + 16'd5, {8'd0, lba_q[23:16]}, ST_OK);
                n = n + 3'd1;
                res[n] = mk_res(K_WB, io_base_q + 16'd7,
                                {8'd0, (cmd_e'(rk_q) == CMD_WRITE) ? CmdWrite : CmdRead},
                                ST_OK);
                n = n + 3'd1;
                pc_d = '0; phase_d = PH_DRQ;
              end
              res[n] = mk_res(K_RB, ctrl_q, '0, ST_OK); n = n + 3'd1;
            end else if (phase_q == PH_WBSY) begin
              end_chk = 1'b1;
            end else begin
              phase_d = PH_FSTAT;
              res[n] = mk_res(K_RB, io_base_q + 16'd7, '0, ST_OK); n = n + 3'd1;
            end
          end
          PH_DLY: begin
            if (pc_q < 23'd4) begin
              pc_d = pc1;
            end else begin
              pc_d = '0; phase_d = PH_W2;
            end
            res[n] = mk_res(K_RB, ctrl_q, '0, ST_OK); n = n + 3'd1;
          end
          PH_DRQ: begin
            if (s == StAllOnes || s[5] || s[0]) begin
              phase_d = PH_IDLE;
              res[n] = mk_res(K_DONE, '0, '0, ST_IOERR); n = n + 3'd1;
            end else if (!s[7] && s[3]) begin
              wi_d = '0;
              if (cmd_e'(rk_q) == CMD_WRITE) begin
                phase_d = PH_WR;
                res[n] = mk_res(K_NEED, '0, '0, ST_OK); n = n + 3'd1;
              end else begin
                phase_d = PH_RD;
                res[n] = mk_res(K_RW, io_base_q, '0, ST_OK); n = n + 3'd1;
              end
            end else begin
              pc_d = pc1;
              if (pc1 >= lim) begin
                phase_d = PH_IDLE;
                res[n] = mk_res(K_DONE, '0, '0, ST_IOERR); n = n + 3'd1;
              end else begin
                res[n] = mk_res(K_RB, ctrl_q, '0, ST_OK); n = n + 3'd1;
              end
            end
          end
          PH_RD: begin
            res[n] = mk_res(K_DELIV, '0, item_i.data_in, ST_OK); n = n + 3'd1;
            wi_d = wi_q + 9'd1;
            if (wi_d < 9'(WordsPerSector)) begin
              res[n] = mk_res(K_RW, io_base_q, '0, ST_OK); n = n + 3'd1;
            end else begin
              end_sec = 1'b1;
            end
          end
          PH_FSTAT: begin
            phase_d = PH_IDLE;
            res[n] = mk_res(K_DONE, '0, '0, (s[5] || s[0]) ? ST_IOERR : ST_OK);
            n = n + 3'd1;
          end
          default: ;
        endcase
      end else if (op_e'(item_i.op) == OP_HOSTW && phase_q == PH_WR) begin
        res[n] = mk_res(K_WW, io_base_q, item_i.data_in, ST_OK); n = n + 3'd1;
        wi_d = wi_q + 9'd1;
        if (wi_d < 9'(WordsPerSector)) begin
          res[n] = mk_res(K_NEED, '0, '0, ST_OK); n = n + 3'd1;
        end else begin
          end_sec = 1'b1;
        end
      end
      // sector finished
      if (end_sec) begin
        sec_d = sec_q + 8'd1;
        if (sec_d < chk_q) begin
          pc_d = '0; phase_d = PH_DRQ;
          res[n] = mk_res(K_RB, ctrl_q, '0, ST_OK); n = n + 3'd1;
        end else if (cmd_e'(rk_q) == CMD_WRITE) begin
          pc_d = '0; phase_d = PH_WBSY;
          res[n] = mk_res(K_RB, ctrl_q, '0, ST_OK); n = n + 3'd1;
        end else begin
          end_chk = 1'b1;
        end
      end
      // chunk finished
      if (end_chk) begin
        lba_d = lba_q + {20'd0, chk_q};
        rem_d = rem_q - {21'd0, chk_q};
        if (rem_d == '0) begin
          phase_d = PH_IDLE;
          res[n] = mk_res(K_DONE, '0, '0, ST_OK); n = n + 3'd1;
        end else begin
          chk_d = (rem_d > 29'(MaxChunk)) ? 8'(MaxChunk) : rem_d[7:0];
          sec_d = '0; pc_d = '0; phase_d = PH_W1;
          res[n] = mk_res(K_RB, ctrl_q, '0, ST_OK); n = n + 3'd1;
        end
      end
    end
  end

  assign push_o       = accept_i && (n != '0);
  assign bundle_o.res = res;
  assign bundle_o.cnt = n;

  // sequencer state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      rk_q    <= '0;
      lba_q   <= '0;
      rem_q   <= '0;
      chk_q   <= '0;
      sec_q   <= '0;
      wi_q    <= '0;
      pc_q    <= '0;
    end else begin
      phase_q <= phase_d;
      rk_q    <= rk_d;
      lba_q   <= lba_d;
      rem_q   <= rem_d;
      chk_q   <= chk_d;
      sec_q   <= sec_d;
      wi_q    <= wi_d;
      pc_q    <= pc_d;
    end
  end

endmodule

// File: rtl/apcs_queue.sv
// ----------------------------------------------------------------------------
// apcs_queue
// Short queue of result bundles; hands out their results one item at a time.
// ----------------------------------------------------------------------------
module apcs_queue import apcs_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      push_i,
  input  bundle_t   bundle_i,
  output logic      full_o,
  output logic      empty_o,
  input  logic      pop_i,
  output out_item_t item_o
);

  bundle_t    mem_q [QueueDepth];
  logic       head_q, tail_q;
  logic [1:0] count_q;
  logic [2:0] idx_q;
  logic       pop_en, last_res, drop;
  bundle_t    head_b;

  assign head_b   = mem_q[head_q];
  assign full_o   = (count_q == 2'(QueueDepth));
  assign empty_o  = (count_q == '0);
  assign pop_en   = pop_i && !empty_o;
  assign last_res = (idx_q == head_b.cnt - 3'd1);
  assign drop     = pop_en && last_res;

  // present current result
  always_comb begin
    item_o      = head_b.res[idx_q];
    item_o.last = last_res;
  end

  // bundle storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[tail_q] <= bundle_i;
    end
  end

  // pointers and counts
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q  <= 1'b0;
      tail_q  <= 1'b0;
      count_q <= '0;
      idx_q   <= '0;
    end else begin
      if (push_i) begin
        tail_q <= ~tail_q;
      end
      if (drop) begin
        head_q <= ~head_q;
        idx_q  <= '0;
      end else if (pop_en) begin
        idx_q <= idx_q + 3'd1;
      end
      count_q <= count_q + {1'b0, push_i} - {1'b0, drop};
    end
  end

  // checks
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !full_o) else $error("bundle pushed into full queue");
  a_nonempty_bundle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> bundle_i.cnt != '0) else $error("empty bundle pushed");
  a_idx_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty_o |-> idx_q < head_b.cnt) else $error("result index past bundle end");
  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= 2'(QueueDepth)) else $error("queue count out of range");

endmodule

// File: rtl/ata_pio_command_sequencer.sv
// ----------------------------------------------------------------------------
// ata_pio_command_sequencer
// Host-side ATA PIO LBA28 sequencer: requests in, bus accesses and host
// words out.
// ----------------------------------------------------------------------------
// Input items (requests, bus read responses, host write words) are pushed
// with push while full is low. Results (bus accesses, host word requests,
// delivered words, done) are read with pop while empty is low; last marks
// the final result caused by one input item.
// An accepted item updates the sequencer state and its results (up to six;
// none for a misplaced item) enter a two-bundle queue. Items can be taken
// every cycle while full is low; the output side drains one result per
// cycle while pop is high, and full rises once two bundles wait.
// Configuration writes (cfg_we_i, cfg_idx_i, cfg_data_i) are registered;
// the user must make them only while the block is idle; the block itself
// does not enforce this. Reset empties the queue, returns the sequencer to
// idle and loads the register reset values. A stalled output side backs up
// the queue and, once it is full, holds off new input items.
// ----------------------------------------------------------------------------
module ata_pio_command_sequencer import apcs_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push,
  output logic        full,
  input  in_item_t    in_data_i,
  output logic        empty,
  input  logic        pop,
  output out_item_t   out_data_o,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [22:0] cfg_data_i
);

  logic    accept, q_push;
  bundle_t bundle;

  assign accept = push && !full;

  apcs_front u_front (
    .clk_i,
    .rst_ni,
    .accept_i   (accept),
    .item_i     (in_data_i),
    .cfg_we_i,
    .cfg_idx_i,
    .cfg_data_i,
    .push_o     (q_push),
    .bundle_o   (bundle)
  );

  apcs_queue u_queue (
    .clk_i,
    .rst_ni,
    .push_i   (q_push),
    .bundle_i (bundle),
    .full_o   (full),
    .empty_o  (empty),
    .pop_i    (pop),
    .item_o   (out_data_o)
  );

endmodule

// File: dv/ata_pio_command_sequencer_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ata_pio_command_sequencer_tb
// Self-checking bench for the ATA PIO LBA28 sequencer. A short directed run
// covers rejected, empty and out-of-range requests, a flush with a failing
// final status and misplaced items. Random runs under several register
// settings then answer the bus reads of the block with plausible status
// bytes and data. Each result is checked against a software sequencer that
// tracks every accepted item.
// ----------------------------------------------------------------------------
module ata_pio_command_sequencer_tb;
  import apcs_pkg::*;

  localparam int unsigned CycleLimit = 3000000;

  typedef enum int {
    S_IDLE, S_W1, S_DLY, S_W2, S_DRQ, S_RD, S_WR, S_WBSY, S_FBSY, S_FSTAT
  } seq_state_e;

  // software sequencer and store of pending bus accesses
  class access_scoreboard;
    logic [15:0] io_base, ctl_port;
    logic        drv;
    logic [22:0] spin;
    seq_state_e  st;
    logic [1:0]  req_kind;
    logic [27:0] lba;
    logic [28:0] remaining;
    logic [7:0]  chunk, sector;
    logic [8:0]  word;
    logic [22:0] polls;
    out_item_t   expq[$];
    out_item_t   burst[$];
    int          errors;

    function new();
      io_base = 16'd496; ctl_port = 16'd1014; drv = 1'b0; spin = SpinReset;
      st = S_IDLE; req_kind = '0; lba = '0; remaining = '0;
      chunk = '0; sector = '0; word = '0; polls = '0; errors = 0;
    endfunction

    function void write_reg(reg_e idx, logic [22:0] data);
      case (idx)
        REG_IO_BASE: io_base = data[15:0];
        REG_CONTROL: ctl_port = data[15:0];
        REG_DRIVE:   drv = data[0];
        default:     spin = data;
      endcase
    endfunction

    function void emit(kind_e k, logic [15:0] p, logic [15:0] v, status_e s);
      out_item_t r;
      r.kind = k; r.port = p; r.value = v; r.status_code = s; r.last = 1'b0;
      burst.push_back(r);
    endfunction

    function logic [15:0] tf(logic [15:0] off);
      return io_base + off;
    endfunction

    function void finish(status_e s);
      emit(K_DONE, '0, '0, s);
      st = S_IDLE;
    endfunction

    function void poll(seq_state_e nxt);
      polls = '0;
      st = nxt;
      emit(K_RB, ctl_port, '0, ST_OK);
    endfunction

    // one more failed poll; true once the wait has run out
    function bit spent();
      logic [22:0] lim;
      lim = (spin == 0) ? 23'd1 : spin;
      polls = polls + 1'b1;
      if (polls >= lim) return 1'b1;
      emit(K_RB, ctl_port, '0, ST_OK);
      return 1'b0;
    endfunction

    function void begin_chunk();
      chunk = (remaining > MaxChunk) ? 8'(MaxChunk) : remaining[7:0];
      sector = '0;
      poll(S_W1);
    endfunction

    function void end_chunk();
      lba = lba + 28'(chunk);
      remaining = remaining - 29'(chunk);
      if (remaining == 0) finish(ST_OK);
      else begin_chunk();
    endfunction

    function void end_sector();
      sector = sector + 1'b1;
      if (sector < chunk) poll(S_DRQ);
      else if (req_kind == CMD_WRITE) poll(S_WBSY);
      else end_chunk();
    endfunction

    function void new_request(logic [1:0] cmd, logic [47:0] blk, logic [31:0] cnt);
      logic [63:0] lim;
      lim = 64'h1000_0000;
      if (cmd == CMD_UNSUP) begin
        finish(ST_UNSUP);
        return;
      end
      req_kind = cmd;
      if (cmd == CMD_FLUSH) begin
        lba = '0;
        poll(S_W1);
        return;
      end
      if (64'(blk) >= lim || 64'(cnt) > lim - 64'(blk)) begin
        finish(ST_RANGE);
        return;
      end
      if (cnt == 0) begin
        finish(ST_OK);
        return;
      end
      lba = blk[27:0];
      remaining = cnt[28:0];
      begin_chunk();
    endfunction

    function void response(logic [15:0] d);
      logic [7:0] s;
      s = d[7:0];
      case (st)
        S_W1, S_W2, S_WBSY, S_FBSY: begin
          if (s == StAllOnes) begin
            finish(ST_IOERR);
            return;
          end
          if (s[7]) begin
            if (spent()) finish(ST_IOERR);
            return;
          end
          if (st == S_W1) begin
            emit(K_WB, tf(6), {8'h0, DevBase | {3'b0, drv, 4'b0} | {4'b0, lba[27:24]}},
                 ST_OK);
            polls = 23'd1;
            st = S_DLY;
            emit(K_RB, ctl_port, '0, ST_OK);
          end else if (st == S_W2) begin
            if (req_kind == CMD_FLUSH) begin
              emit(K_WB, tf(7), {8'h0, CmdFlush}, ST_OK);
              poll(S_FBSY);
            end else begin
              emit(K_WB, tf(2), {8'h0, chunk}, ST_OK);
              emit(K_WB, tf(3), {8'h0, lba[7:0]}, ST_OK);
              emit(K_WB, tf(4), {8'h0, lba[15:8]}, ST_OK);
              emit(K_WB, tf(5), {8'h0, lba[23:16]}, ST_OK);
              emit(K_WB, tf(7), {8'h0, (req_kind == CMD_WRITE) ? CmdWrite : CmdRead},
                   ST_OK);
              poll(S_DRQ);
            end
          end else if (st == S_WBSY) begin
            end_chunk();
          end else begin
            st = S_FSTAT;
            emit(K_RB, tf(7), '0, ST_OK);
          end
        end
        S_DLY: begin
          if (polls < 4) begin
            polls = polls + 1'b1;
            emit(K_RB, ctl_port, '0, ST_OK);
          end else begin
            poll(S_W2);
          end
        end
        S_DRQ: begin
          if (s == StAllOnes || s[5] || s[0]) begin
            finish(ST_IOERR);
            return;
          end
          if (!s[7] && s[3]) begin
            word = '0;
            if (req_kind == CMD_WRITE) begin
              st = S_WR;
              emit(K_NEED, '0, '0, ST_OK);
            end else begin
              st = S_RD;
              emit(K_RW, tf(0), '0, ST_OK);
            end
            return;
          end
          if (spent()) finish(ST_IOERR);
        end
        S_RD: begin
          emit(K_DELIV, '0, d, ST_OK);
          word = word + 1'b1;
          if (word < WordsPerSector) emit(K_RW, tf(0), '0, ST_OK);
          else end_sector();
        end
        S_FSTAT: finish((s[5] || s[0]) ? ST_IOERR : ST_OK);
        default: ;
      endcase
    endfunction

    // accepted input item: work out the results it causes
    function void note_item(in_item_t it);
      burst.delete();
      if (it.op == OP_REQ && st == S_IDLE) begin
        new_request(it.cmd, it.start_block, it.block_count);
      end else if (it.op == OP_RESP && st != S_IDLE && st != S_WR) begin
        response(it.data_in);
      end else if (it.op == OP_HOSTW && st == S_WR) begin
        emit(K_WW, tf(0), it.data_in, ST_OK);
        word = word + 1'b1;
        if (word < WordsPerSector) emit(K_NEED, '0, '0, ST_OK);
        else end_sector();
      end
      if (burst.size() > 0) burst[burst.size()-1].last = 1'b1;
      foreach (burst[i]) expq.push_back(burst[i]);
    endfunction

    function void check_result(out_item_t got);
      out_item_t exp_r;
      if (expq.size() == 0) begin
        errors++;
        $display("%0t: unexpected result kind=%0d port=%h value=%h status=%0d last=%b",
                 $time, got.kind, got.port, got.value, got.status_code, got.last);
        return;
      end
      exp_r = expq.pop_front();
      if (got !== exp_r) begin
        errors++;
        $display("%0t: result mismatch expected kind=%0d port=%h value=%h status=%0d last=%b",
                 $time, exp_r.kind, exp_r.port, exp_r.value, exp_r.status_code, exp_r.last);
        $display("%0t:                   actual kind=%0d port=%h value=%h status=%0d last=%b",
                 $time, got.kind, got.port, got.value, got.status_code, got.last);
      end
    endfunction
  endclass

  logic        clk_i;
  logic        rst_ni;
  logic        push;
  logic        full;
  in_item_t    in_data_i;
  logic        empty;
  logic        pop;
  out_item_t   out_data_o;
  logic        cfg_we_i;
  logic [1:0]  cfg_idx_i;
  logic [22:0] cfg_data_i;

  access_scoreboard sb;
  bit          quiet;
  bit          hold_req;
  int unsigned cycles;

  ata_pio_command_sequencer uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push       (push),
    .full       (full),
    .in_data_i  (in_data_i),
    .empty      (empty),
    .pop        (pop),
    .out_data_o (out_data_o),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i)
  );

  // clock
  always begin
    clk_i = 1'b1; #5;
    clk_i = 1'b0; #5;
  end

  // run limit
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("ata_pio_command_sequencer_tb: errors");
      $finish;
    end
  end

  // result checking
  always @(posedge clk_i) begin
    if (rst_ni && pop && !empty) sb.check_result(out_data_o);
  end

  // result side: random stalls and one long hold
  initial begin
    pop <= 1'b0;
    @(posedge rst_ni);
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        pop <= 1'b0;
        repeat (300) @(posedge clk_i);
      end else if (!quiet && $urandom_range(0, 4) == 0) begin
        pop <= 1'b0;
        repeat ($urandom_range(1, 11)) @(posedge clk_i);
      end else begin
        pop <= 1'b1;
        @(posedge clk_i);
      end
    end
  end

  // offer one item and hold it until taken
  task automatic send(in_item_t it);
    in_data_i <= it;
    push <= 1'b1;
    do @(posedge clk_i); while (full);
    sb.note_item(it);
  endtask

  task automatic maybe_gap();
    if (!quiet && $urandom_range(0, 3) == 0) begin
      push <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk_i);
    end
  endtask

  task automatic send_fields(op_e op, cmd_e cmd, logic [47:0] blk, logic [31:0] cnt,
                             logic [15:0] d);
    in_item_t it;
    it.op = op; it.cmd = cmd; it.start_block = blk; it.block_count = cnt;
    it.data_in = d;
    send(it);
  endtask

  // wait for the block to drain, then write all registers
  task automatic set_regs(logic [15:0] base, logic [15:0] ctl, logic drv,
                          logic [22:0] spin);
    logic [22:0] vals[4];
    vals[0] = 23'(base); vals[1] = 23'(ctl); vals[2] = 23'(drv); vals[3] = spin;
    push <= 1'b0;
    while (sb.expq.size() != 0) @(posedge clk_i);
    repeat (5) @(posedge clk_i);
    for (int i = 0; i < 4; i++) begin
      cfg_we_i <= 1'b1;
      cfg_idx_i <= 2'(i);
      cfg_data_i <= vals[i];
      @(posedge clk_i);
      sb.write_reg(reg_e'(i), vals[i]);
    end
    cfg_we_i <= 1'b0;
  endtask

  // status byte for a busy wait
  function automatic logic [7:0] busy_status(bit hurry);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (hurry || r < 5) return StAllOnes;
    if (r < 22) return 8'($urandom) | 8'h80;
    return 8'($urandom) & 8'h7f;
  endfunction

  // status byte for a data request wait
  function automatic logic [7:0] drq_status(bit hurry);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (hurry || r < 5) return StAllOnes;
    if (r < 12) return (8'($urandom) & 8'h7f) | (r[0] ? 8'h20 : 8'h01);
    if (r < 25) return 8'($urandom) | 8'h80;
    if (r < 32) return 8'($urandom) & 8'h56;
    return (8'($urandom) & 8'h56) | 8'h08;
  endfunction

  // next well-formed item for the current state, or noise
  function automatic in_item_t next_item(bit hurry, output bit counted);
    in_item_t it;
    int unsigned r;
    it = in_item_t'(100'({$urandom, $urandom, $urandom, $urandom}));
    it.data_in = 16'($urandom);
    counted = (sb.st != S_RD && sb.st != S_WR);
    if (!hurry && $urandom_range(0, 99) < 8) begin
      // noise: any op, far-out start so no long transfer can begin
      it.start_block[47] = 1'b1;
      counted = 1'b0;
      return it;
    end
    case (sb.st)
      S_IDLE: begin
        it.op = OP_REQ;
        r = $urandom_range(0, 19);
        it.cmd = (r < 7) ? CMD_READ : (r < 14) ? CMD_WRITE : (r < 17) ? CMD_FLUSH
                                                                      : CMD_UNSUP;
        r = $urandom_range(0, 9);
        if (r < 5) it.start_block = 48'($urandom_range(0, 1000));
        else if (r < 7) it.start_block = 48'h1000_0000 - 48'($urandom_range(1, 3));
        else if (r < 8) it.start_block = 48'h1000_0000 + 48'($urandom_range(0, 3));
        if ($urandom_range(0, 3) != 0) it.block_count = 32'($urandom_range(0, 2));
        else if ($urandom_range(0, 1) == 0) it.block_count = 32'hffff_ffff;
        if (it.start_block < 48'h1000_0000 && it.block_count > 3 &&
            64'(it.block_count) <= 64'h1000_0000 - 64'(it.start_block))
          it.block_count = 32'(it.block_count[1:0]);
      end
      S_W1, S_W2, S_WBSY, S_FBSY: begin
        it.op = OP_RESP;
        it.data_in[7:0] = busy_status(hurry);
      end
      S_DRQ: begin
        it.op = OP_RESP;
        it.data_in[7:0] = drq_status(hurry);
      end
      S_WR: it.op = OP_HOSTW;
      default: it.op = OP_RESP;
    endcase
    return it;
  endfunction

  task automatic random_run(int unsigned n);
    in_item_t it;
    bit counted;
    int unsigned done_cnt;
    done_cnt = 0;
    while (done_cnt < n) begin
      it = next_item(1'b0, counted);
      send(it);
      if (counted) done_cnt++;
      maybe_gap();
    end
    // finish the open request quickly
    while (sb.st != S_IDLE) begin
      it = next_item(1'b1, counted);
      send(it);
    end
  endtask

  initial begin
    sb = new();
    quiet = 1'b0;
    hold_req = 1'b0;
    cycles = 0;
    rst_ni <= 1'b0;
    push <= 1'b0;
    in_data_i <= '0;
    cfg_we_i <= 1'b0;
    cfg_idx_i <= REG_IO_BASE;
    cfg_data_i <= '0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: misplaced items, rejected and empty requests
    send_fields(OP_NONE, CMD_READ, '0, '0, 16'hffff);
    send_fields(OP_RESP, CMD_READ, '0, '0, 16'h0000);
    send_fields(OP_HOSTW, CMD_WRITE, '0, '0, 16'h1234);
    send_fields(OP_REQ, CMD_UNSUP, '0, '0, '0);
    send_fields(OP_REQ, CMD_READ, 48'h1000_0000, 32'd1, '0);
    send_fields(OP_REQ, CMD_WRITE, 48'hffff_ffff_ffff, 32'hffff_ffff, '0);
    send_fields(OP_REQ, CMD_READ, '0, 32'hffff_ffff, '0);
    send_fields(OP_REQ, CMD_READ, 48'h0fff_fffe, 32'd3, '0);
    send_fields(OP_REQ, CMD_WRITE, 48'h0fff_ffff, 32'd0, '0);
    send_fields(OP_REQ, CMD_READ, '0, 32'd0, '0);
    // flush with busy status once, then failing final status
    send_fields(OP_REQ, CMD_FLUSH, 48'h0abc_dead, 32'd9, '0);
    send_fields(OP_REQ, CMD_READ, '0, 32'd1, '0);
    send_fields(OP_RESP, CMD_READ, '0, '0, 16'hff80);
    send_fields(OP_RESP, CMD_READ, '0, '0, 16'h0050);
    for (int i = 0; i < 4; i++) send_fields(OP_RESP, CMD_READ, '0, '0, 16'(i));
    send_fields(OP_RESP, CMD_READ, '0, '0, 16'h0040);
    send_fields(OP_RESP, CMD_READ, '0, '0, 16'h0000);
    send_fields(OP_RESP, CMD_READ, '0, '0, 16'h0021);
    // read that dies on an all-ones status
    send_fields(OP_REQ, CMD_READ, 48'h0fff_ffff, 32'd1, '0);
    send_fields(OP_RESP, CMD_READ, '0, '0, 16'h00ff);

    // random runs under several register settings
    set_regs(16'h0000, 16'hffff, 1'b1, 23'h7f_ffff);
    random_run(45);
    set_regs(16'hffff, 16'h0000, 1'b0, 23'd0);
    hold_req = 1'b1;
    random_run(45);
    set_regs(16'($urandom), 16'($urandom), 1'($urandom), 23'd3);
    random_run(45);
    set_regs(16'd496, 16'd1014, 1'b0, SpinReset);
    quiet = 1'b1;
    random_run(45);

    push <= 1'b0;
    while (sb.expq.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (sb.errors == 0) begin
      $display("ata_pio_command_sequencer_tb: clean");
    end else begin
      $display("ata_pio_command_sequencer_tb: errors");
    end
    $finish;
  end

endmodule
